// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge.
`define SLCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define SLCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slcfp_pkg.sv =====
// ---------------------------------------------------------------------------
// slcfp_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// framed packet receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcfp_pkg;

  localparam int MAX_BODY_DEF = 64;
  localparam int PREFIX_LEN   = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] VERSION_RST     = 8'h01;
  localparam logic [6:0] BODY_LIMIT_RST  = 7'd64;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_BODY_LIMIT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_LEN_ERR = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_VER_ERR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CRC_HOLD,
    CRC_LOAD_INIT,
    CRC_LOAD_SF,
    CRC_PAIR,
    CRC_ACC
  } crc_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ERR,
    OUT_EMPTY,
    OUT_DATA
  } out_op_e;

  typedef struct packed {
    crc_op_e crc_op;
    logic    len_hi_load;
    logic    body_clr;
    logic    body_wr;
    logic    crch_load;
    logic    emit_clr;
    logic    emit_adv;
    out_op_e out_op;
    kind_e   out_kind;
  } cmd_t;

  typedef struct packed {
    logic b_is_sf;
    logic b_is_ss;
    logic lenh_is_sf;
    logic crch_is_sf;
    logic len_bad;
    logic crc_ok;
    logic ver_ok;
    logic plen_zero;
    logic body_done;
    logic emit_last;
    logic out_free;
  } status_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = ((c & CRC_MSB) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_SF_RST = crc_byte(CRC_INIT, SYNC_FIRST_RST);

endpackage

// ===== rtl/core/slcfp_rx_if.sv =====
// ---------------------------------------------------------------------------
// slcfp_rx_if
// Received byte channel: valid/ready handshake carrying one link byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/slcfp_res_if.sv =====
// ---------------------------------------------------------------------------
// slcfp_res_if
// Result channel: valid/ready handshake carrying one frame data or error result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slcfp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] message_id;
  logic [7:0] sequence_number;
  logic [7:0] frame_flags;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;

  modport source (
    output valid, output kind, output message_id, output sequence_number,
    output frame_flags, output payload_byte, output byte_valid, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input message_id, input sequence_number,
    input frame_flags, input payload_byte, input byte_valid, input last,
    output ready
  );
endinterface

// ===== rtl/core/sync_length_crc_frame_parser_top.sv =====
// ---------------------------------------------------------------------------
// sync_length_crc_frame_parser_top
// Framed packet receiver with sync pair, 16-bit length, body and
// CRC-16/CCITT-FALSE check; releases the payload of good frames.
// ---------------------------------------------------------------------------
// Received bytes are taken at one per cycle while a frame is parsed; the byte
// that completes the length field or the CRC is taken only once the result
// register is free or being emptied in the same cycle. After a frame with a
// good CRC and version, its n payload bytes drain from the body store, each by
// a registered memory read and then an output register load that waits for a
// free result register, and no input byte is taken during the drain. The body
// store needs no clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_length_crc_frame_parser_top #(
  parameter int MAX_BODY = slcfp_pkg::MAX_BODY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  slcfp_rx_if.sink    rx_i,
  slcfp_res_if.source res_o
);

  slcfp_pkg::cmd_t    cmd;
  slcfp_pkg::status_t status;
  logic               rx_ready;

  assign rx_i.ready = rx_ready;

  slcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slcfp_dp #(
    .MAX_BODY (MAX_BODY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/core/slcfp_ctrl.sv =====
// ---------------------------------------------------------------------------
// slcfp_ctrl
// Frame parser state machine: sync, length, body and CRC phases, then the
// payload drain. Issues datapath commands from datapath status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slcfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  slcfp_pkg::status_t status_i,
  output slcfp_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_LENH,
    ST_LENL,
    ST_BODY,
    ST_CRCH,
    ST_CRCL,
    ST_FETCH,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   rx_acc;

  always_comb begin
    unique case (state_q)
      ST_SYNC0, ST_SYNC1, ST_LENH, ST_BODY, ST_CRCH: rx_ready_o = 1'b1;
      ST_LENL, ST_CRCL: rx_ready_o = status_i.out_free;
      default: rx_ready_o = 1'b0;
    endcase
  end

  assign rx_acc = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d              = state_q;
    cmd_o.crc_op         = slcfp_pkg::CRC_HOLD;
    cmd_o.len_hi_load    = 1'b0;
    cmd_o.body_clr       = 1'b0;
    cmd_o.body_wr        = 1'b0;
    cmd_o.crch_load      = 1'b0;
    cmd_o.emit_clr       = 1'b0;
    cmd_o.emit_adv       = 1'b0;
    cmd_o.out_op         = slcfp_pkg::OUT_NONE;
    cmd_o.out_kind       = slcfp_pkg::KIND_DATA;
    unique case (state_q)
      ST_SYNC0: begin
        if (rx_acc && status_i.b_is_sf) begin
          cmd_o.crc_op = slcfp_pkg::CRC_LOAD_SF;
          state_d      = ST_SYNC1;
        end
      end
      ST_SYNC1: begin
        if (rx_acc) begin
          if (status_i.b_is_ss) begin
            cmd_o.crc_op = slcfp_pkg::CRC_ACC;
            state_d      = ST_LENH;
          end else if (status_i.b_is_sf) begin
            cmd_o.crc_op = slcfp_pkg::CRC_LOAD_SF;
            state_d      = ST_SYNC1;
          end else begin
            cmd_o.crc_op = slcfp_pkg::CRC_LOAD_INIT;
            state_d      = ST_SYNC0;
          end
        end
      end
      ST_LENH: begin
        if (rx_acc) begin
          cmd_o.len_hi_load = 1'b1;
          cmd_o.crc_op      = slcfp_pkg::CRC_ACC;
          state_d           = ST_LENL;
        end
      end
      ST_LENL: begin
        if (rx_acc) begin
          if (status_i.len_bad) begin
            cmd_o.out_op   = slcfp_pkg::OUT_ERR;
            cmd_o.out_kind = slcfp_pkg::KIND_LEN_ERR;
            if (status_i.lenh_is_sf && status_i.b_is_ss) begin
              cmd_o.crc_op = slcfp_pkg::CRC_PAIR;
              state_d      = ST_LENH;
            end else if (status_i.b_is_sf) begin
              cmd_o.crc_op = slcfp_pkg::CRC_LOAD_SF;
              state_d      = ST_SYNC1;
            end else begin
              cmd_o.crc_op = slcfp_pkg::CRC_LOAD_INIT;
              state_d      = ST_SYNC0;
            end
          end else begin
            cmd_o.body_clr = 1'b1;
            cmd_o.crc_op   = slcfp_pkg::CRC_ACC;
            state_d        = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (rx_acc) begin
          cmd_o.body_wr = 1'b1;
          cmd_o.crc_op  = slcfp_pkg::CRC_ACC;
          if (status_i.body_done) begin
            state_d = ST_CRCH;
          end
        end
      end
      ST_CRCH: begin
        if (rx_acc) begin
          cmd_o.crch_load = 1'b1;
          state_d         = ST_CRCL;
        end
      end
      ST_CRCL: begin
        if (rx_acc) begin
          priority if (!status_i.crc_ok) begin
            cmd_o.out_op   = slcfp_pkg::OUT_ERR;
            cmd_o.out_kind = slcfp_pkg::KIND_CRC_ERR;
            if (status_i.crch_is_sf && status_i.b_is_ss) begin
              cmd_o.crc_op = slcfp_pkg::CRC_PAIR;
              state_d      = ST_LENH;
            end else if (status_i.b_is_sf) begin
              cmd_o.crc_op = slcfp_pkg::CRC_LOAD_SF;
              state_d      = ST_SYNC1;
            end else begin
              cmd_o.crc_op = slcfp_pkg::CRC_LOAD_INIT;
              state_d      = ST_SYNC0;
            end
          end else if (!status_i.ver_ok) begin
            cmd_o.out_op   = slcfp_pkg::OUT_ERR;
            cmd_o.out_kind = slcfp_pkg::KIND_VER_ERR;
            cmd_o.crc_op   = slcfp_pkg::CRC_LOAD_INIT;
            state_d        = ST_SYNC0;
          end else if (status_i.plen_zero) begin
            cmd_o.out_op = slcfp_pkg::OUT_EMPTY;
            cmd_o.crc_op = slcfp_pkg::CRC_LOAD_INIT;
            state_d      = ST_SYNC0;
          end else begin
            cmd_o.emit_clr = 1'b1;
            cmd_o.crc_op   = slcfp_pkg::CRC_LOAD_INIT;
            state_d        = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_op   = slcfp_pkg::OUT_DATA;
          cmd_o.emit_adv = 1'b1;
          state_d        = status_i.emit_last ? ST_SYNC0 : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC0;
    end else begin
      state_q <= state_d;
    end
  end

  `SLCFP_ASSERT(a_out_load_free, (cmd_o.out_op == slcfp_pkg::OUT_NONE) || status_i.out_free, "result loaded into a busy output register")
  `SLCFP_ASSERT_NEXT(a_drain_ends, (state_q == ST_LOAD) && status_i.out_free && status_i.emit_last, (state_q == ST_SYNC0), "drain did not end after last payload byte")
  `SLCFP_ASSERT(a_no_rx_in_drain, !((state_q == ST_FETCH) || (state_q == ST_LOAD)) || !rx_ready_o, "input taken during payload drain")

endmodule

// ===== rtl/core/slcfp_dp.sv =====
// ---------------------------------------------------------------------------
// slcfp_dp
// Parser datapath: configuration registers, length and CRC registers, body
// store, header bytes and the result output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slcfp_dp #(
  parameter int MAX_BODY = slcfp_pkg::MAX_BODY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic [7:0]           rx_byte_i,
  input  slcfp_pkg::cmd_t      cmd_i,
  output slcfp_pkg::status_t   status_o,
  slcfp_res_if.source          res_o
);

  localparam int ADDR_W = $clog2(MAX_BODY);
  localparam int CNT_W  = $clog2(MAX_BODY + 1);
  localparam logic [15:0] MaxBody16  = 16'(MAX_BODY);
  localparam logic [15:0] Prefix16   = 16'(slcfp_pkg::PREFIX_LEN);
  localparam logic [15:0] PrefixP116 = 16'(slcfp_pkg::PREFIX_LEN + 1);

  logic [7:0]  sync_first_q, sync_second_q, version_q;
  logic [6:0]  body_limit_q;
  logic [15:0] crc_sf_q;

  logic [7:0]        len_hi_q;
  logic [15:0]       len_q;
  logic [CNT_W-1:0]  body_count_q;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crch_q;
  logic [7:0]        hdr_q [4];
  logic [ADDR_W-1:0] emit_q;

  logic [7:0]        mem [MAX_BODY];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] rd_addr;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_id_q, out_seq_q, out_flags_q, out_pb_q;
  logic        out_bv_q, out_last_q;

  logic [15:0] len16, limit16, base_crc;
  logic        load;

  // Configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slcfp_pkg::SYNC_FIRST_RST;
      sync_second_q <= slcfp_pkg::SYNC_SECOND_RST;
      version_q     <= slcfp_pkg::VERSION_RST;
      body_limit_q  <= slcfp_pkg::BODY_LIMIT_RST;
      crc_sf_q      <= slcfp_pkg::CRC_SF_RST;
    end else if (cfg_we_i) begin
      unique case (slcfp_pkg::cfg_reg_e'(cfg_idx_i))
        slcfp_pkg::CFG_SYNC_FIRST: begin
          sync_first_q <= cfg_wdata_i;
          crc_sf_q     <= slcfp_pkg::crc_byte(slcfp_pkg::CRC_INIT, cfg_wdata_i);
        end
        slcfp_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        slcfp_pkg::CFG_VERSION:     version_q     <= cfg_wdata_i;
        slcfp_pkg::CFG_BODY_LIMIT:  body_limit_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign len16   = {len_hi_q, rx_byte_i};
  assign limit16 = ({9'd0, body_limit_q} < MaxBody16) ? {9'd0, body_limit_q} : MaxBody16;
  assign rd_addr = ADDR_W'(slcfp_pkg::PREFIX_LEN) + emit_q;

  assign status_o.b_is_sf    = (rx_byte_i == sync_first_q);
  assign status_o.b_is_ss    = (rx_byte_i == sync_second_q);
  assign status_o.lenh_is_sf = (len_hi_q == sync_first_q);
  assign status_o.crch_is_sf = (crch_q == sync_first_q);
  assign status_o.len_bad    = (len16 < Prefix16) || (len16 > limit16);
  assign status_o.crc_ok     = ({crch_q, rx_byte_i} == crc_q);
  assign status_o.ver_ok     = (hdr_q[0] == version_q);
  assign status_o.plen_zero  = (len_q == Prefix16);
  assign status_o.body_done  = ((16'(body_count_q) + 16'd1) >= len_q);
  assign status_o.emit_last  = ((16'(emit_q) + PrefixP116) == len_q);
  assign status_o.out_free   = !out_valid_q || res_o.ready;

  always_comb begin
    base_crc = (cmd_i.crc_op == slcfp_pkg::CRC_PAIR) ? crc_sf_q : crc_q;
    unique case (cmd_i.crc_op)
      slcfp_pkg::CRC_LOAD_INIT:           crc_d = slcfp_pkg::CRC_INIT;
      slcfp_pkg::CRC_LOAD_SF:             crc_d = crc_sf_q;
      slcfp_pkg::CRC_PAIR,
      slcfp_pkg::CRC_ACC:                 crc_d = slcfp_pkg::crc_byte(base_crc, rx_byte_i);
      default:                            crc_d = crc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= slcfp_pkg::CRC_INIT;
      body_count_q <= '0;
      emit_q       <= '0;
    end else begin
      crc_q <= crc_d;
      if (cmd_i.body_clr) begin
        body_count_q <= '0;
      end else if (cmd_i.body_wr) begin
        body_count_q <= body_count_q + CNT_W'(1);
      end
      if (cmd_i.emit_clr) begin
        emit_q <= '0;
      end else if (cmd_i.emit_adv) begin
        emit_q <= emit_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_hi_load) begin
      len_hi_q <= rx_byte_i;
    end
    if (cmd_i.body_clr) begin
      len_q <= len16;
    end
    if (cmd_i.crch_load) begin
      crch_q <= rx_byte_i;
    end
    if (cmd_i.body_wr && (16'(body_count_q) < Prefix16)) begin
      hdr_q[body_count_q[1:0]] <= rx_byte_i;
    end
  end

  // Body store
  always_ff @(posedge clk_i) begin
    if (cmd_i.body_wr) begin
      mem[body_count_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  // Result output register
  assign load = (cmd_i.out_op != slcfp_pkg::OUT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.out_op)
      slcfp_pkg::OUT_ERR: begin
        out_kind_q  <= cmd_i.out_kind;
        out_id_q    <= 8'h00;
        out_seq_q   <= 8'h00;
        out_flags_q <= 8'h00;
        out_pb_q    <= 8'h00;
        out_bv_q    <= 1'b0;
        out_last_q  <= 1'b1;
      end
      slcfp_pkg::OUT_EMPTY: begin
        out_kind_q  <= slcfp_pkg::KIND_DATA;
        out_id_q    <= hdr_q[1];
        out_seq_q   <= hdr_q[2];
        out_flags_q <= hdr_q[3];
        out_pb_q    <= 8'h00;
        out_bv_q    <= 1'b0;
        out_last_q  <= 1'b1;
      end
      slcfp_pkg::OUT_DATA: begin
        out_kind_q  <= slcfp_pkg::KIND_DATA;
        out_id_q    <= hdr_q[1];
        out_seq_q   <= hdr_q[2];
        out_flags_q <= hdr_q[3];
        out_pb_q    <= rdata_q;
        out_bv_q    <= 1'b1;
        out_last_q  <= status_o.emit_last;
      end
      default: ;
    endcase
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_kind_q;
  assign res_o.message_id      = out_id_q;
  assign res_o.sequence_number = out_seq_q;
  assign res_o.frame_flags     = out_flags_q;
  assign res_o.payload_byte    = out_pb_q;
  assign res_o.byte_valid      = out_bv_q;
  assign res_o.last            = out_last_q;

  `SLCFP_ASSERT(a_body_wr_in_len, !cmd_i.body_wr || (16'(body_count_q) < len_q), "body write beyond frame length")
  `SLCFP_ASSERT_NEXT(a_data_kind, (cmd_i.out_op == slcfp_pkg::OUT_DATA), (out_valid_q && out_bv_q && (out_kind_q == slcfp_pkg::KIND_DATA)), "payload result without data kind")
  `SLCFP_ASSERT(a_err_single, !(out_valid_q && (out_kind_q != slcfp_pkg::KIND_DATA)) || (out_last_q && !out_bv_q), "error result not a single last transfer")

endmodule
